/* hw/rtl/bine_pkg.sv */
package bine_pkg;

    localparam int IDX_BITS = 10;

    localparam logic [3:0] OP_CLEAR  = 4'd0;
    localparam logic [3:0] OP_LOOKUP = 4'd1;
    localparam logic [3:0] OP_FIND   = 4'd2;
    localparam logic [3:0] OP_READ   = 4'd3;
    localparam logic [3:0] OP_SETKEY = 4'd4;
    localparam logic [3:0] OP_ROOT   = 4'd5;
    localparam logic [3:0] OP_INSERT = 4'd6;
    localparam logic [3:0] OP_REMOVE = 4'd7;
    localparam logic [3:0] OP_APPEND = 4'd8;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_INDEX   = 3'd1;
    localparam logic [2:0] STS_NOCHILD = 3'd2;
    localparam logic [2:0] STS_FULL    = 3'd3;
    localparam logic [2:0] STS_FEW     = 3'd4;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LE,
        CELL_PICK_HIT,
        CELL_PICK_IDX,
        CELL_WRITE_KEY,
        CELL_WRITE_BOTH,
        CELL_NEW_ROOT,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     remove;
    } cell_ctrl_t;

    typedef struct packed {
        logic                found;
        logic [IDX_BITS-1:0] idx;
        logic [63:0]         key;
        logic [30:0]         child;
    } chain_bus_t;

endpackage

/* hw/rtl/bine_cell.sv */
module bine_cell #(
    parameter int INDEX    = 0,
    parameter int PW       = 9,
    parameter int KEY_BITS = 64
) (
    input  logic                aclk,
    input  bine_pkg::cell_ctrl_t ctrl,
    input  logic [PW-1:0]       pos,
    input  logic [PW-1:0]       cnt,
    input  logic [KEY_BITS-1:0] key_in,
    input  logic [30:0]         child_in,
    input  logic [30:0]         alt_child,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [30:0]         left_child,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic [30:0]         right_child,
    output logic [KEY_BITS-1:0] key_q,
    output logic [30:0]         child_q,
    output logic                le_q,
    input  bine_pkg::chain_bus_t bus_in,
    output bine_pkg::chain_bus_t bus_out
);
    import bine_pkg::*;

    localparam logic [PW-1:0] POS    = PW'(INDEX);
    localparam logic [PW:0]   POS_P1 = (PW + 1)'(INDEX + 1);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [30:0]         child_reg, child_next;
    logic                pick_reg, pick_next;
    logic                le_reg, le_next;
    chain_bus_t          bus_reg, bus_next;

    always_comb begin
        key_next   = key_reg;
        child_next = child_reg;
        pick_next  = pick_reg;
        le_next    = le_reg;
        if (ctrl.remove) begin
            if (POS >= pos && POS_P1 < {1'b0, cnt}) begin
                key_next   = right_key;
                child_next = right_child;
            end
        end else begin
            unique case (ctrl.op)
                CELL_LE:       le_next = (key_reg <= key_in);
                CELL_PICK_HIT: pick_next = (POS < cnt) && (child_reg == alt_child);
                CELL_PICK_IDX: pick_next = (POS == pos);
                CELL_WRITE_KEY: begin
                    if (POS == pos) key_next = key_in;
                end
                CELL_WRITE_BOTH: begin
                    if (POS == pos) begin
                        key_next   = key_in;
                        child_next = child_in;
                    end
                end
                CELL_NEW_ROOT: begin
                    if (INDEX == 0) child_next = alt_child;
                    if (INDEX == 1) begin
                        key_next   = key_in;
                        child_next = child_in;
                    end
                end
                CELL_INSERT: begin
                    if (POS == pos) begin
                        key_next   = key_in;
                        child_next = child_in;
                    end else if (POS > pos && POS <= cnt) begin
                        key_next   = left_key;
                        child_next = left_child;
                    end
                end
                default: ;
            endcase
        end
        bus_next = bus_in;
        if (!bus_in.found && pick_reg) begin
            bus_next.found = 1'b1;
            bus_next.idx   = IDX_BITS'(INDEX);
            bus_next.key   = 64'(key_reg);
            bus_next.child = child_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        child_reg <= child_next;
        pick_reg  <= pick_next;
        le_reg    <= le_next;
        bus_reg   <= bus_next;
    end

    assign key_q   = key_reg;
    assign child_q = child_reg;
    assign le_q    = le_reg;
    assign bus_out = bus_reg;

endmodule

/* hw/rtl/btree_internal_node_engine_core.sv */
// Clear, set key, new root, remove, append and every early error finish in the dispatch
// state; find child, read and insert go on to a pass along the chain of CAPACITY entry
// cells, and lookup first runs its binary-search steps and then makes the same pass.
// One request is in work at a time, and the next may be accepted while the last result
// waits.
// Reset clears the entry count and the result valid, and sets max_entries to 256.
module btree_internal_node_engine_core #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_in[63:0], child_in[94:64], match_child[125:95], index_in[133:126], zeros
    input  logic [135:0] s_tdata,
    // opcode[3:0]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // child_out[30:0], key_out[94:31], index_out[102:95], count_out[111:103]
    output logic [111:0] m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser,
    input  logic         cfg_tvalid,
    output logic         cfg_tready,
    input  logic [8:0]   cfg_tdata
);
    import bine_pkg::*;

    localparam int PW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (PW > 9) ? PW : 9;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_SEARCH   = 6'b000100,
        ST_PASS     = 6'b001000,
        ST_DONE     = 6'b010000,
        ST_SPARE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [30:0]         child_reg, child_next;
    logic [30:0]         match_reg, match_next;
    logic [7:0]          idx_reg, idx_next;
    logic [PW-1:0]       count_reg, count_next;
    logic [8:0]          max_reg, max_next;
    logic [PW-1:0]       l_reg, l_next, r_reg, r_next;
    logic [PW-1:0]       pass_reg, pass_next;
    logic [2:0]          sts_reg, sts_next;
    logic [30:0]         cho_reg, cho_next;
    logic [63:0]         keo_reg, keo_next;
    logic [7:0]          ixo_reg, ixo_next;
    logic                mv_reg, mv_next;
    logic [111:0]        md_reg, md_next;
    logic [2:0]          mu_reg, mu_next;

    cell_ctrl_t          ctrl;
    logic [PW-1:0]       pos;
    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [30:0]         cell_child [CAPACITY];
    logic [CAPACITY-1:0] le_vec;
    chain_bus_t          bus_w [CAPACITY+1];
    chain_bus_t          tail;
    logic [PW:0]         mid_sum;
    logic [IW-1:0]       mid;
    logic                is_full, idx_bad;

    assign bus_w[0] = '0;
    assign tail     = bus_w[CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_BITS-1:0] lk, rk;
        logic [30:0]         lc, rc;
        if (g == 0) begin : g_l0
            assign lk = '0;
            assign lc = '0;
        end else begin : g_ln
            assign lk = cell_key[g-1];
            assign lc = cell_child[g-1];
        end
        if (g == CAPACITY - 1) begin : g_r0
            assign rk = '0;
            assign rc = '0;
        end else begin : g_rn
            assign rk = cell_key[g+1];
            assign rc = cell_child[g+1];
        end
        bine_cell #(.INDEX(g), .PW(PW), .KEY_BITS(KEY_BITS)) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .pos        (pos),
            .cnt        (count_reg),
            .key_in     (key_reg),
            .child_in   (child_reg),
            .alt_child  (match_reg),
            .left_key   (lk),
            .left_child (lc),
            .right_key  (rk),
            .right_child(rc),
            .key_q      (cell_key[g]),
            .child_q    (cell_child[g]),
            .le_q       (le_vec[g]),
            .bus_in     (bus_w[g]),
            .bus_out    (bus_w[g+1])
        );
    end

    assign is_full  = (CMPW'(count_reg) >= CMPW'(max_reg)) || (count_reg == PW'(CAPACITY));
    assign idx_bad  = CMPW'(idx_reg) >= CMPW'(count_reg);
    assign mid_sum  = (PW + 1)'(l_reg) + (PW + 1)'(r_reg);
    assign mid      = mid_sum[IW:1];

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        child_next = child_reg;
        match_next = match_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        max_next   = max_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        pass_next  = pass_reg;
        sts_next   = sts_reg;
        cho_next   = cho_reg;
        keo_next   = keo_reg;
        ixo_next   = ixo_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        mu_next    = mu_reg;
        ctrl       = '{op: CELL_HOLD, remove: 1'b0};
        pos        = '0;

        if (cfg_tvalid) max_next = cfg_tdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[KEY_BITS-1:0];
                    child_next = s_tdata[94:64];
                    match_next = s_tdata[125:95];
                    idx_next   = s_tdata[133:126];
                    sts_next   = STS_OK;
                    cho_next   = '0;
                    keo_next   = '0;
                    ixo_next   = '0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = ST_DONE;
                pass_next  = '0;
                unique case (op_reg) inside
                    OP_CLEAR: count_next = '0;
                    OP_LOOKUP: begin
                        if (count_reg < PW'(2)) begin
                            sts_next = STS_FEW;
                        end else begin
                            ctrl.op    = CELL_LE;
                            l_next     = PW'(1);
                            r_next     = count_reg - PW'(1);
                            state_next = ST_SEARCH;
                        end
                    end
                    OP_FIND, OP_INSERT: begin
                        ctrl.op    = CELL_PICK_HIT;
                        state_next = ST_PASS;
                    end
                    OP_READ: begin
                        if (idx_bad) begin
                            sts_next = STS_INDEX;
                        end else begin
                            ctrl.op    = CELL_PICK_IDX;
                            pos        = PW'(idx_reg);
                            state_next = ST_PASS;
                        end
                    end
                    OP_SETKEY: begin
                        if (idx_bad) begin
                            sts_next = STS_INDEX;
                        end else begin
                            ctrl.op = CELL_WRITE_KEY;
                            pos     = PW'(idx_reg);
                        end
                    end
                    OP_ROOT: begin
                        ctrl.op    = CELL_NEW_ROOT;
                        count_next = PW'(2);
                    end
                    OP_REMOVE: begin
                        if (idx_bad) begin
                            sts_next = STS_INDEX;
                        end else begin
                            ctrl.remove = 1'b1;
                            pos         = PW'(idx_reg);
                            count_next  = count_reg - PW'(1);
                        end
                    end
                    OP_APPEND: begin
                        if (is_full) begin
                            sts_next = STS_FULL;
                        end else begin
                            ctrl.op    = CELL_WRITE_BOTH;
                            pos        = count_reg;
                            count_next = count_reg + PW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            ST_SEARCH: begin
                if (l_reg > r_reg) begin
                    ctrl.op    = CELL_PICK_IDX;
                    pos        = l_reg - PW'(1);
                    state_next = ST_PASS;
                end else if (le_vec[mid]) begin
                    l_next = PW'(mid) + PW'(1);
                end else begin
                    r_next = PW'(mid) - PW'(1);
                end
            end
            ST_PASS: begin
                pass_next = pass_reg + PW'(1);
                if (pass_reg == PW'(CAPACITY)) begin
                    state_next = ST_DONE;
                    unique case (op_reg)
                        OP_FIND: begin
                            if (tail.found) ixo_next = tail.idx[7:0];
                            else            sts_next = STS_NOCHILD;
                        end
                        OP_INSERT: begin
                            if (!tail.found) begin
                                sts_next = STS_NOCHILD;
                            end else if (is_full) begin
                                sts_next = STS_FULL;
                            end else begin
                                ctrl.op    = CELL_INSERT;
                                pos        = PW'(tail.idx) + PW'(1);
                                count_next = count_reg + PW'(1);
                            end
                        end
                        OP_READ: begin
                            cho_next = tail.child;
                            keo_next = tail.key;
                        end
                        default: cho_next = tail.child;
                    endcase
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {9'(count_reg), ixo_reg, keo_reg, cho_reg};
                    mu_next    = sts_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            max_reg   <= 9'd256;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            max_reg   <= max_next;
            mv_reg    <= mv_next;
        end
        op_reg    <= op_next;
        key_reg   <= key_next;
        child_reg <= child_next;
        match_reg <= match_next;
        idx_reg   <= idx_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        pass_reg  <= pass_next;
        sts_reg   <= sts_next;
        cho_reg   <= cho_next;
        keo_reg   <= keo_next;
        ixo_reg   <= ixo_next;
        md_reg    <= md_next;
        mu_reg    <= mu_next;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_tready = 1'b1;
    assign m_tvalid   = mv_reg;
    assign m_tdata    = md_reg;
    assign m_tuser    = mu_reg;

endmodule

/* hw/rtl/bine_checker.sv */
module bine_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [2:0]   m_tuser
);
    import bine_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result was not held.");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= STS_FEW)
        else $error("Status code out of range.");

    a_few: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STS_FEW |-> m_tdata[111:103] < 9'd2)
        else $error("Too few entries reported with a count of two or more.");

    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STS_INDEX |-> m_tdata[102:0] == '0)
        else $error("Index error carried result data.");

endmodule

bind btree_internal_node_engine_core bine_checker u_bine_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

/* test/bine_node_checker.sv */
module bine_node_checker
    import bine_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic [3:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         cfg_tvalid,
    input  logic         cfg_tready,
    input  logic [8:0]   cfg_tdata,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] child;
        logic [63:0] key;
        logic [7:0]  index;
        logic [8:0]  count;
    } node_reply_t;

    logic [63:0] node_keys [256];
    logic [30:0] node_kids [256];
    int unsigned node_count;
    int unsigned entry_limit;
    node_reply_t expected_replies[$];
    int          mismatch_count;

    function automatic int locate_child(logic [30:0] c);
        for (int i = 0; i < node_count; i++) begin
            if (node_kids[i] == c) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic node_reply_t node_apply(logic [3:0] op, logic [63:0] key,
                                               logic [30:0] child, logic [30:0] match,
                                               logic [7:0] idx);
        node_reply_t r;
        int pos;
        int lo;
        int hi;
        int mid;
        int unsigned lim;
        r = '0;
        r.status = STS_OK;
        lim = (entry_limit > 256) ? 256 : entry_limit;
        case (op)
            OP_CLEAR: begin
                node_count = 0;
            end
            OP_LOOKUP: begin
                if (node_count < 2) begin
                    r.status = STS_FEW;
                end else begin
                    lo = 1;
                    hi = node_count - 1;
                    while (lo <= hi) begin
                        mid = (hi - lo) / 2 + lo;
                        if (node_keys[mid] <= key) lo = mid + 1;
                        else hi = mid - 1;
                    end
                    r.child = node_kids[lo - 1];
                end
            end
            OP_FIND: begin
                pos = locate_child(match);
                if (pos < 0) r.status = STS_NOCHILD;
                else r.index = pos[7:0];
            end
            OP_READ: begin
                if (idx >= node_count) begin
                    r.status = STS_INDEX;
                end else begin
                    r.key = node_keys[idx];
                    r.child = node_kids[idx];
                end
            end
            OP_SETKEY: begin
                if (idx >= node_count) r.status = STS_INDEX;
                else node_keys[idx] = key;
            end
            OP_ROOT: begin
                node_kids[0] = match;
                node_keys[1] = key;
                node_kids[1] = child;
                node_count = 2;
            end
            OP_INSERT: begin
                pos = locate_child(match);
                if (pos < 0) begin
                    r.status = STS_NOCHILD;
                end else if (node_count >= lim) begin
                    r.status = STS_FULL;
                end else begin
                    for (int i = node_count; i > pos + 1; i--) begin
                        node_keys[i] = node_keys[i - 1];
                        node_kids[i] = node_kids[i - 1];
                    end
                    node_keys[pos + 1] = key;
                    node_kids[pos + 1] = child;
                    node_count++;
                end
            end
            OP_REMOVE: begin
                if (idx >= node_count) begin
                    r.status = STS_INDEX;
                end else begin
                    for (int i = idx + 1; i < node_count; i++) begin
                        node_keys[i - 1] = node_keys[i];
                        node_kids[i - 1] = node_kids[i];
                    end
                    node_count--;
                end
            end
            OP_APPEND: begin
                if (node_count >= lim) begin
                    r.status = STS_FULL;
                end else begin
                    node_keys[node_count] = key;
                    node_kids[node_count] = child;
                    node_count++;
                end
            end
            default: begin
            end
        endcase
        r.count = node_count[8:0];
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        mismatch_count = 0;
        node_count = 0;
        entry_limit = 256;
    end

    always @(posedge aclk) begin
        node_reply_t want;
        node_reply_t got;
        if (!aresetn) begin
            node_count = 0;
            entry_limit = 256;
            expected_replies.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.child = m_tdata[30:0];
                got.key = m_tdata[94:31];
                got.index = m_tdata[102:95];
                got.count = m_tdata[111:103];
                if (expected_replies.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Unexpected reply: status %0d count %0d",
                                 got.status, got.count);
                    end
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status) note_mismatch("status", want.status, got.status);
                    if (got.child !== want.child) note_mismatch("child_out", want.child, got.child);
                    if (got.key !== want.key) note_mismatch("key_out", want.key, got.key);
                    if (got.index !== want.index) note_mismatch("index_out", want.index, got.index);
                    if (got.count !== want.count) note_mismatch("count_out", want.count, got.count);
                end
            end
            if (cfg_tvalid && cfg_tready) begin
                entry_limit = cfg_tdata;
            end
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(node_apply(s_tuser, s_tdata[63:0], s_tdata[94:64],
                                                      s_tdata[125:95], s_tdata[133:126]));
            end
        end
        pending = expected_replies.size();
    end

endmodule

/* test/btree_internal_node_engine_core_tb.sv */
module btree_internal_node_engine_core_tb;
    import bine_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_tvalid;
    logic         cfg_tready;
    logic [8:0]   cfg_tdata;
    int           fail_count;
    int           pending;
    int           cycles;
    int           requests_sent;
    bit           brisk;
    bit           long_hold;
    bit           entry0_key_set;

    localparam int DRAIN_CYCLES = 270;
    localparam int CYCLE_LIMIT = 2000000;

    btree_internal_node_engine_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
    );

    bine_node_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles.", cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, with one long hold when asked.
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (800) @(posedge aclk);
            end else begin
                gap = brisk ? 0 : $urandom_range(0, 12);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic issue_request(logic [3:0] op, logic [63:0] key, logic [30:0] child,
                                 logic [30:0] match, logic [7:0] idx);
        int gap;
        // The key of entry 0 is never written by a new root, so it must not be read back.
        if (op == OP_READ && idx == 0 && !entry0_key_set) idx = 8'd1;
        if (op == OP_ROOT) entry0_key_set = 1'b0;
        if (op == OP_CLEAR || op == OP_REMOVE && idx == 0 || op == OP_SETKEY && idx == 0)
            entry0_key_set = 1'b1;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, idx, match, child, key};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        gap = brisk ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_node();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_entry_limit(logic [8:0] value);
        drain_node();
        cfg_tvalid <= 1'b1;
        cfg_tdata <= value;
        do @(posedge aclk); while (!cfg_tready);
        cfg_tvalid <= 1'b0;
    endtask

    function automatic logic [30:0] pick_child();
        if ($urandom_range(0, 3) == 0) return 31'($urandom);
        return 31'($urandom_range(0, 40));
    endfunction

    function automatic logic [63:0] pick_key();
        return {$urandom, $urandom};
    endfunction

    task automatic random_request();
        int n;
        logic [7:0] idx;
        n = $urandom_range(0, 99);
        idx = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 20));
        if (n < 3) issue_request(OP_CLEAR, pick_key(), pick_child(), pick_child(), idx);
        else if (n < 6) issue_request(OP_ROOT, pick_key(), pick_child(), pick_child(), idx);
        else if (n < 26) issue_request(OP_APPEND, pick_key(), pick_child(), pick_child(), idx);
        else if (n < 38) issue_request(OP_INSERT, pick_key(), pick_child(), pick_child(), idx);
        else if (n < 50) issue_request(OP_LOOKUP, pick_key(), pick_child(), pick_child(), idx);
        else if (n < 60) issue_request(OP_FIND, pick_key(), pick_child(), pick_child(), idx);
        else if (n < 70) issue_request(OP_READ, pick_key(), pick_child(), pick_child(), idx);
        else if (n < 78) issue_request(OP_SETKEY, pick_key(), pick_child(), pick_child(), idx);
        else if (n < 88) issue_request(OP_REMOVE, pick_key(), pick_child(), pick_child(), idx);
        else if (n < 92) issue_request(4'($urandom_range(9, 15)), pick_key(), 31'($urandom),
                                       31'($urandom), 8'($urandom));
        else issue_request(4'($urandom), pick_key(), 31'($urandom), 31'($urandom),
                           8'($urandom));
    endtask

    initial begin
        logic [8:0] limits [5] = '{9'd2, 9'd7, 9'd511, 9'd300, 9'd256};
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_CLEAR;
        cfg_tvalid <= 1'b0;
        cfg_tdata <= '0;
        brisk = 1'b0;
        long_hold = 1'b0;
        entry0_key_set = 1'b1;
        requests_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty node errors, then a small tree with extreme keys and children.
        issue_request(OP_LOOKUP, '0, '0, '0, 8'd0);
        issue_request(OP_READ, '0, '0, '0, 8'd0);
        issue_request(OP_REMOVE, '0, '0, '0, 8'd0);
        issue_request(OP_FIND, '0, '0, '0, 8'd0);
        issue_request(OP_INSERT, '1, '1, '0, 8'd0);
        issue_request(OP_ROOT, '1, '1, '0, 8'd0);
        issue_request(OP_LOOKUP, '0, '0, '0, 8'd0);
        issue_request(OP_LOOKUP, '1, '0, '0, 8'd0);
        issue_request(OP_APPEND, '0, '0, '0, 8'd0);
        issue_request(OP_INSERT, 64'h8000_0000_0000_0000, 31'd5, '1, 8'd0);
        issue_request(OP_FIND, '0, '0, '1, 8'd0);
        issue_request(OP_READ, '0, '0, '0, 8'd1);
        issue_request(OP_SETKEY, '1, '0, '0, 8'd255);
        issue_request(OP_SETKEY, 64'd3, '0, '0, 8'd1);
        issue_request(OP_REMOVE, '0, '0, '0, 8'd0);
        issue_request(OP_READ, '0, '0, '0, 8'd0);
        issue_request(4'd15, '1, '1, '1, 8'd255);
        issue_request(4'd9, '0, '0, '0, 8'd0);
        issue_request(OP_CLEAR, '0, '0, '0, 8'd0);
        set_entry_limit(9'd2);
        issue_request(OP_ROOT, 64'd10, 31'd2, 31'd1, 8'd0);
        issue_request(OP_APPEND, 64'd20, 31'd3, '0, 8'd0);
        issue_request(OP_INSERT, 64'd15, 31'd4, 31'd1, 8'd0);
        issue_request(OP_INSERT, 64'd15, 31'd4, 31'd9, 8'd0);

        // Fill the node to capacity with the register above it.
        set_entry_limit(9'd511);
        brisk = 1'b1;
        issue_request(OP_CLEAR, '0, '0, '0, 8'd0);
        for (int i = 0; i < 258; i++) begin
            issue_request(OP_APPEND, 64'(i * 1000), 31'(i), '0, 8'd0);
        end
        brisk = 1'b0;
        long_hold = 1'b1;
        for (int i = 0; i < 6; i++) begin
            issue_request(OP_LOOKUP, 64'($urandom_range(0, 260000)), '0, '0, 8'd0);
        end
        issue_request(OP_INSERT, '0, 31'd1, 31'd255, 8'd0);
        issue_request(OP_FIND, '0, '0, 31'd255, 8'd0);
        issue_request(OP_READ, '0, '0, '0, 8'd255);
        issue_request(OP_REMOVE, '0, '0, '0, 8'd17);

        foreach (limits[p]) begin
            set_entry_limit(limits[p]);
            brisk = (p == 2);
            for (int i = 0; i < 310; i++) random_request();
        end
        brisk = 1'b0;

        drain_node();
        $display("Sent %0d requests over entry limits 2, 7, 256, 300 and 511,", requests_sent);
        $display("including a full node, every opcode and every error status.");
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
